### src/ubds_pkg.sv
// Shared constants and types for the UART baud divisor search block.
package ubds_pkg;

    localparam int unsigned CLK_HZ_W         = 32;
    localparam int unsigned BAUD_W           = 22;
    localparam int unsigned GEN_W            = 30;
    localparam int unsigned DIV_OUT_W        = 8;
    localparam int unsigned ERR_W            = 32;
    localparam int unsigned APB_DATA_W       = 32;
    localparam int unsigned APB_ADDR_W       = 3;

    localparam int unsigned MIN_DIVISOR_DEF   = 4;
    localparam int unsigned DIVISOR_LIMIT_DEF = 255;

    localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 32'd100000000;
    localparam logic [ERR_W-1:0]    NONE_ERROR   = 32'hFFFF_FFFF;

    localparam logic [0:0] REG_INPUT_CLOCK_HZ = 1'b0;

    typedef struct packed {
        logic                start;
        logic [CLK_HZ_W-1:0] dividend;
        logic [CLK_HZ_W-1:0] divisor;
    } ubds_div_req_t;

    typedef struct packed {
        logic                done;
        logic [CLK_HZ_W-1:0] quotient;
    } ubds_div_resp_t;

endpackage

### src/ubds_regs.sv
// APB configuration register bank holding the reference clock frequency.
module ubds_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ubds_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ubds_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ubds_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [ubds_pkg::CLK_HZ_W-1:0]       clk_hz
);

    logic [ubds_pkg::CLK_HZ_W-1:0] clk_hz_reg;
    logic                          sel_clk_hz;

    assign sel_clk_hz = (paddr[ubds_pkg::APB_ADDR_W-1:2] == ubds_pkg::REG_INPUT_CLOCK_HZ);
    assign pready     = 1'b1;
    assign clk_hz     = clk_hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= ubds_pkg::CLK_HZ_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_clk_hz)
        begin
            clk_hz_reg <= pwdata;
        end
    end

    always_comb
    begin
        if (sel_clk_hz)
        begin
            prdata = clk_hz_reg;
        end
        else
        begin
            prdata = '0;
        end
    end

endmodule

### src/ubds_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module ubds_divider
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ubds_pkg::ubds_div_req_t  req,
    output ubds_pkg::ubds_div_resp_t resp
);

    localparam int unsigned W   = ubds_pkg::CLK_HZ_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = !diff[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

### src/ubds_search.sv
// Search sequencer: shared multiplier, divider requests and best-candidate tracking.
module ubds_search
#(
    parameter int unsigned MIN_DIVISOR   = ubds_pkg::MIN_DIVISOR_DEF,
    parameter int unsigned DIVISOR_LIMIT = ubds_pkg::DIVISOR_LIMIT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ubds_pkg::CLK_HZ_W-1:0]     clk_hz,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ubds_pkg::BAUD_W-1:0]       baud_rate,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ubds_pkg::GEN_W-1:0]        generator_value,
    output logic [ubds_pkg::DIV_OUT_W-1:0]    bit_divisor,
    output logic [ubds_pkg::ERR_W-1:0]        rate_error,
    output logic                              found,
    output ubds_pkg::ubds_div_req_t           div_req,
    input  ubds_pkg::ubds_div_resp_t          div_resp
);

    localparam int unsigned W  = ubds_pkg::CLK_HZ_W;
    localparam int unsigned DW = $clog2(DIVISOR_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_EVAL,
        S_CMP,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    logic                            phase_reg;
    logic [DW-1:0]                   d_reg;
    logic [ubds_pkg::BAUD_W-1:0]     baud_reg;
    logic [W-1:0]                    prod_reg;
    logic [W-1:0]                    g_reg;
    logic [W-1:0]                    ach_reg;
    logic [ubds_pkg::ERR_W-1:0]      err_reg;
    logic [W-1:0]                    best_g_reg;
    logic [DW-1:0]                   best_d_reg;
    logic [ubds_pkg::ERR_W-1:0]      best_err_reg;
    logic                            best_found_reg;
    logic                            out_valid_reg;
    logic [ubds_pkg::GEN_W-1:0]      gen_out_reg;
    logic [ubds_pkg::DIV_OUT_W-1:0]  div_out_reg;
    logic [ubds_pkg::ERR_W-1:0]      err_out_reg;
    logic                            found_out_reg;

    logic [DW-1:0]                   factor;
    logic [W-1:0]                    mul_a;
    logic [W-1:0]                    mul_p;
    logic [W-1:0]                    baud_ext;

    assign baud_ext = W'(baud_reg);
    assign factor   = d_reg + 1'b1;
    assign mul_a    = phase_reg ? g_reg : baud_ext;
    assign mul_p    = W'(mul_a * W'(factor));

    assign div_req.start    = (state_reg == S_DIV_START) && (prod_reg != '0);
    assign div_req.dividend = clk_hz;
    assign div_req.divisor  = prod_reg;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign generator_value = gen_out_reg;
    assign bit_divisor     = div_out_reg;
    assign rate_error      = err_out_reg;
    assign found           = found_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= 1'b0;
            d_reg          <= '0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        baud_reg       <= baud_rate;
                        d_reg          <= DW'(MIN_DIVISOR);
                        phase_reg      <= 1'b0;
                        best_g_reg     <= '0;
                        best_d_reg     <= '0;
                        best_err_reg   <= ubds_pkg::NONE_ERROR;
                        best_found_reg <= 1'b0;
                        state_reg      <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    state_reg <= (prod_reg == '0) ? S_NEXT : S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_resp.done)
                    begin
                        if (!phase_reg)
                        begin
                            g_reg <= div_resp.quotient;
                            if (div_resp.quotient == '0)
                            begin
                                state_reg <= S_NEXT;
                            end
                            else
                            begin
                                phase_reg <= 1'b1;
                                state_reg <= S_MUL;
                            end
                        end
                        else
                        begin
                            ach_reg   <= div_resp.quotient;
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    err_reg   <= (ach_reg > baud_ext) ? (ach_reg - baud_ext)
                                                      : (baud_ext - ach_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!best_found_reg || (err_reg < best_err_reg))
                    begin
                        best_g_reg     <= g_reg;
                        best_d_reg     <= d_reg;
                        best_err_reg   <= err_reg;
                        best_found_reg <= 1'b1;
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    phase_reg <= 1'b0;
                    if (d_reg == DW'(DIVISOR_LIMIT - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        gen_out_reg   <= best_g_reg[ubds_pkg::GEN_W-1:0];
                        div_out_reg   <= ubds_pkg::DIV_OUT_W'(best_d_reg);
                        err_out_reg   <= best_err_reg;
                        found_out_reg <= best_found_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/uart_baud_divisor_search_top.sv
// Top level of the UART baud divisor search block.
// For each requested baud rate beat the block walks the per-bit divisors
// MIN_DIVISOR to DIVISOR_LIMIT-1 and returns one result beat with the
// generator count, divisor and rate error of the best candidate (lowest
// error, lowest divisor on ties), or found = 0 with an all-ones error. One
// shared 32-bit restoring divider, one bit per cycle, sets the cost: a
// candidate takes two divisions plus multiply, error and compare steps,
// only the first division when its generator count is zero, and no
// division when the baud rate is zero. in_ready is low for the whole
// search; the result sits in an output register until taken.
// input_clock_hz is at APB address 0 and resets to 100000000.
module uart_baud_divisor_search_top
#(
    parameter int unsigned MIN_DIVISOR   = ubds_pkg::MIN_DIVISOR_DEF,
    parameter int unsigned DIVISOR_LIMIT = ubds_pkg::DIVISOR_LIMIT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ubds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ubds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ubds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ubds_pkg::BAUD_W-1:0]       baud_rate,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ubds_pkg::GEN_W-1:0]        generator_value,
    output logic [ubds_pkg::DIV_OUT_W-1:0]    bit_divisor,
    output logic [ubds_pkg::ERR_W-1:0]        rate_error,
    output logic                              found
);

    logic [ubds_pkg::CLK_HZ_W-1:0] clk_hz;
    ubds_pkg::ubds_div_req_t       div_req;
    ubds_pkg::ubds_div_resp_t      div_resp;

    ubds_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .clk_hz  (clk_hz)
    );

    ubds_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    ubds_search
    #(
        .MIN_DIVISOR   (MIN_DIVISOR),
        .DIVISOR_LIMIT (DIVISOR_LIMIT)
    )
    u_search
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .clk_hz          (clk_hz),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .baud_rate       (baud_rate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .generator_value (generator_value),
        .bit_divisor     (bit_divisor),
        .rate_error      (rate_error),
        .found           (found),
        .div_req         (div_req),
        .div_resp        (div_resp)
    );

endmodule

### src/ubds_checker.sv
// Port-level assertions for the UART baud divisor search block.
module ubds_checker
#(
    parameter int unsigned MIN_DIVISOR   = ubds_pkg::MIN_DIVISOR_DEF,
    parameter int unsigned DIVISOR_LIMIT = ubds_pkg::DIVISOR_LIMIT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [ubds_pkg::GEN_W-1:0]        generator_value,
    input  logic [ubds_pkg::DIV_OUT_W-1:0]    bit_divisor,
    input  logic [ubds_pkg::ERR_W-1:0]        rate_error,
    input  logic                              found
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(generator_value)
            && $stable(bit_divisor) && $stable(rate_error) && $stable(found))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a beat");

    a_none_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> generator_value == '0 && bit_divisor == '0
            && rate_error == ubds_pkg::NONE_ERROR)
        else $error("empty result carries nonzero fields");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> generator_value != '0
            && 32'(bit_divisor) >= MIN_DIVISOR && 32'(bit_divisor) < DIVISOR_LIMIT
            && rate_error != ubds_pkg::NONE_ERROR)
        else $error("found result out of range");

endmodule

bind uart_baud_divisor_search_top ubds_checker
#(
    .MIN_DIVISOR   (MIN_DIVISOR),
    .DIVISOR_LIMIT (DIVISOR_LIMIT)
)
u_ubds_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .generator_value (generator_value),
    .bit_divisor     (bit_divisor),
    .rate_error      (rate_error),
    .found           (found)
);
